// ----- hdl/x86ld_pkg.sv -----
// ============================================================================
// x86ld_pkg: shared types, codes and opcode tables for the length decoder
// Holds the decode phases, result codes, prefix bytes and the opcode
// classification functions of the supported x86-64 subset.
// ============================================================================
package x86ld_pkg;

   localparam int MAX_LEN_DEF = 15;

   localparam logic [7:0] PFX_OPSIZE    = 8'h66;
   localparam logic [7:0] PFX_REPNE     = 8'hF2;
   localparam logic [7:0] PFX_REP       = 8'hF3;
   localparam logic [7:0] PFX_ADDR      = 8'h67;
   localparam logic [7:0] PFX_LOCK      = 8'hF0;
   localparam logic [7:0] REX_BASE      = 8'h40;
   localparam logic [7:0] ESC_0F        = 8'h0F;
   localparam logic [7:0] OP_IMUL_IMM32 = 8'h69;
   localparam logic [7:0] OP_IMUL_IMM8  = 8'h6B;
   localparam logic [7:0] OP_MOV_R_IMM  = 8'hB8;
   localparam logic [7:0] OP_MOV_RM_IMM = 8'hC7;
   localparam logic [7:0] OP_CALL       = 8'hE8;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNKNOWN  = 2'd1;
   localparam logic [1:0] ST_TRUNC    = 2'd2;
   localparam logic [1:0] ST_OVERLONG = 2'd3;

   localparam logic [2:0] AM_NONE = 3'd0;
   localparam logic [2:0] AM_REG  = 3'd1;
   localparam logic [2:0] AM_BASE = 3'd2;
   localparam logic [2:0] AM_SIB  = 3'd3;
   localparam logic [2:0] AM_RIP  = 3'd4;

   localparam logic [4:0] NO_INDEX = 5'd16;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_OP0F,
      PH_MODRM,
      PH_SIB,
      PH_DISP,
      PH_IMM
   } phase_type;

   function automatic logic op_known(input logic [8:0] op);
      logic [7:0] b;
      logic       known;
      b = op[7:0];
      known = 1'b0;
      if (op[8]) begin
         if (b[7:4] == 4'h8) begin
            known = 1'b1;
         end else begin
            case (b)
               8'hB6, 8'hB7, 8'hAF, 8'h10, 8'h11, 8'h2A, 8'h2C, 8'h2D, 8'h2E,
               8'h2F, 8'h54, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5C, 8'h5E, 8'h6E,
               8'h7E: known = 1'b1;
               default: known = 1'b0;
            endcase
         end
      end else if (b < 8'h40 && b[2:0] < 3'd4) begin
         known = 1'b1;
      end else if (b[7:4] == 4'h5 || b[7:4] == 4'h7 || b[7:3] == OP_MOV_R_IMM[7:3]) begin
         known = 1'b1;
      end else begin
         case (b)
            8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8D, 8'h63, OP_IMUL_IMM32, OP_IMUL_IMM8,
            OP_MOV_RM_IMM, 8'h81, 8'h83, 8'hD2, 8'hD3, 8'hF7, 8'hFF, 8'hC3, 8'h99,
            8'hFC, 8'hA4, OP_CALL, 8'hE9, 8'hEB: known = 1'b1;
            default: known = 1'b0;
         endcase
      end
      return known;
   endfunction

   function automatic logic op_modrm(input logic [8:0] op);
      logic [7:0] b;
      logic       has;
      b = op[7:0];
      has = 1'b0;
      if (op[8]) begin
         has = (b[7:4] != 4'h8);
      end else if (b < 8'h40) begin
         has = 1'b1;
      end else begin
         case (b)
            8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8D, 8'h63, OP_IMUL_IMM32, OP_IMUL_IMM8,
            OP_MOV_RM_IMM, 8'h81, 8'h83, 8'hD2, 8'hD3, 8'hF7, 8'hFF: has = 1'b1;
            default: has = 1'b0;
         endcase
      end
      return has;
   endfunction

   function automatic logic [3:0] imm_width(input logic [8:0] op, input logic rex_w,
                                            input logic [2:0] modrm_reg);
      logic [7:0] b;
      logic [3:0] w;
      b = op[7:0];
      w = 4'd0;
      if (op[8]) begin
         w = (b[7:4] == 4'h8) ? 4'd4 : 4'd0;
      end else if (b[7:3] == OP_MOV_R_IMM[7:3]) begin
         w = rex_w ? 4'd8 : 4'd4;
      end else if (b[7:4] == 4'h7) begin
         w = 4'd1;
      end else begin
         case (b)
            OP_IMUL_IMM32, OP_MOV_RM_IMM, 8'h81, OP_CALL, 8'hE9: w = 4'd4;
            OP_IMUL_IMM8, 8'h83, 8'hEB: w = 4'd1;
            8'hF7: w = (modrm_reg < 3'd2) ? 4'd4 : 4'd0;
            default: w = 4'd0;
         endcase
      end
      return w;
   endfunction

   function automatic logic [2:0] disp_width(input logic [7:0] modrm, input logic [7:0] sib);
      logic [2:0] w;
      case (modrm[7:6])
         2'd3: w = 3'd0;
         2'd1: w = 3'd1;
         2'd2: w = 3'd4;
         default: begin
            if (modrm[2:0] == 3'd4) begin
               w = (sib[2:0] == 3'd5) ? 3'd4 : 3'd0;
            end else begin
               w = (modrm[2:0] == 3'd5) ? 3'd4 : 3'd0;
            end
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/x86_64_subset_length_decoder_top.sv -----
// ============================================================================
// x86_64_subset_length_decoder_top: streaming x86-64 instruction length decoder
// Takes one code byte per request and emits one record per instruction with
// its length, prefixes, REX bits, addressing fields, displacement and immediate.
// ============================================================================
// A record is built from the byte register and leaves through the result register.
// Throughput: one byte per cycle while the consumer does not stall; the byte register and the result register
// let a new request in while an earlier record waits for the consumer.
// The per-byte phase machine and its accumulators compute their next state combinationally from the held byte.
// Reset (synchronous, active high) returns the decoder to the prefix phase
// with all held fields cleared and both registers empty.
module x86_64_subset_length_decoder_top #(
   parameter int MAX_LEN = x86ld_pkg::MAX_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_code_byte,
   input  logic               req_range_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_length,
   output logic [8:0]         rsp_opcode,
   output logic [3:0]         rsp_rex_bits,
   output logic [2:0]         rsp_prefix_flags,
   output logic [2:0]         rsp_addr_mode,
   output logic [3:0]         rsp_reg_field,
   output logic [3:0]         rsp_rm_or_base,
   output logic [4:0]         rsp_index_reg,
   output logic [1:0]         rsp_scale_log2,
   output logic signed [31:0] rsp_displacement,
   output logic signed [63:0] rsp_immediate,
   output logic [1:0]         rsp_status
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   x86ld_pkg::phase_type phase_ff, phase_in, phase_upd;
   logic [3:0]  cnt_ff, cnt_in;
   logic [8:0]  op_ff, op_in, op_upd;
   logic [3:0]  rex_ff, rex_in, rex_upd;
   logic [2:0]  pfx_ff, pfx_in, pfx_upd;
   logic [7:0]  modrm_ff, modrm_in, modrm_upd;
   logic [7:0]  sib_ff, sib_in, sib_upd;
   logic [31:0] disp_ff, disp_in, disp_upd;
   logic [2:0]  disp_left_ff, disp_left_in, disp_left_upd;
   logic [63:0] imm_ff, imm_in, imm_upd;
   logic [3:0]  imm_left_ff, imm_left_in, imm_left_upd;

   logic [3:0] len;
   logic [2:0] dw_cur, dw_new, disp_diff;
   logic [3:0] iw_cur, iw_new, imm_diff;
   logic       go_disp, go_imm, done, unknown, overlong, emit;
   logic [3:0] sib_idx;

   logic        rsp_vld_ff;
   logic [3:0]  len_ff, len_in;
   logic [8:0]  ropc_ff;
   logic [3:0]  rrex_ff;
   logic [2:0]  rpfx_ff;
   logic [2:0]  am_ff, am_in;
   logic [3:0]  reg_ff, reg_in;
   logic [3:0]  rm_ff, rm_in;
   logic [4:0]  idx_ff, idx_in;
   logic [1:0]  scale_ff, scale_in;
   logic [31:0] rdisp_ff, rdisp_in;
   logic [63:0] rimm_ff, rimm_in;
   logic [1:0]  st_ff, st_in;

   assign advance   = in_vld_ff && !(rsp_vld_ff && rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign in_vld_in = (req_valid && !req_stall) ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_code_byte;
         in_last_ff <= req_range_end;
      end
   end

   always_comb begin
      len           = cnt_ff + 4'd1;
      phase_upd     = phase_ff;
      op_upd        = op_ff;
      rex_upd       = rex_ff;
      pfx_upd       = pfx_ff;
      modrm_upd     = modrm_ff;
      sib_upd       = sib_ff;
      disp_upd      = disp_ff;
      disp_left_upd = disp_left_ff;
      imm_upd       = imm_ff;
      imm_left_upd  = imm_left_ff;
      go_disp       = 1'b0;
      go_imm        = 1'b0;
      done          = 1'b0;
      unknown       = 1'b0;
      dw_cur        = x86ld_pkg::disp_width(modrm_ff, sib_ff);
      iw_cur        = x86ld_pkg::imm_width(op_ff, rex_ff[3], modrm_ff[5:3]);
      disp_diff     = dw_cur - disp_left_ff;
      imm_diff      = iw_cur - imm_left_ff;

      case (phase_ff)
         x86ld_pkg::PH_OP0F: begin
            op_upd = {1'b1, in_byte_ff};
            if (!x86ld_pkg::op_known(op_upd)) begin
               done    = 1'b1;
               unknown = 1'b1;
            end else if (x86ld_pkg::op_modrm(op_upd)) begin
               phase_upd = x86ld_pkg::PH_MODRM;
            end else begin
               go_imm = 1'b1;
            end
         end
         x86ld_pkg::PH_MODRM: begin
            modrm_upd = in_byte_ff;
            if (in_byte_ff[7:6] != 2'd3 && in_byte_ff[2:0] == 3'd4) begin
               phase_upd = x86ld_pkg::PH_SIB;
            end else begin
               go_disp = 1'b1;
            end
         end
         x86ld_pkg::PH_SIB: begin
            sib_upd = in_byte_ff;
            go_disp = 1'b1;
         end
         x86ld_pkg::PH_DISP: begin
            disp_upd[{disp_diff[1:0], 3'b000} +: 8] =
               disp_ff[{disp_diff[1:0], 3'b000} +: 8] | in_byte_ff;
            disp_left_upd = disp_left_ff - 3'd1;
            if (disp_left_upd == 3'd0) begin
               go_imm = 1'b1;
            end
         end
         x86ld_pkg::PH_IMM: begin
            imm_upd[{imm_diff[2:0], 3'b000} +: 8] =
               imm_ff[{imm_diff[2:0], 3'b000} +: 8] | in_byte_ff;
            imm_left_upd = imm_left_ff - 4'd1;
            if (imm_left_upd == 4'd0) begin
               done = 1'b1;
            end
         end
         default: begin
            if (in_byte_ff == x86ld_pkg::PFX_OPSIZE) begin
               pfx_upd = pfx_ff | 3'b001;
               rex_upd = 4'd0;
            end else if (in_byte_ff == x86ld_pkg::PFX_REPNE) begin
               pfx_upd = {2'b01, pfx_ff[0]};
               rex_upd = 4'd0;
            end else if (in_byte_ff == x86ld_pkg::PFX_REP) begin
               pfx_upd = {2'b10, pfx_ff[0]};
               rex_upd = 4'd0;
            end else if (in_byte_ff == x86ld_pkg::PFX_ADDR ||
                         in_byte_ff == x86ld_pkg::PFX_LOCK) begin
               rex_upd = 4'd0;
            end else if (in_byte_ff[7:4] == x86ld_pkg::REX_BASE[7:4]) begin
               rex_upd = in_byte_ff[3:0];
            end else if (in_byte_ff == x86ld_pkg::ESC_0F) begin
               op_upd    = 9'h100;
               phase_upd = x86ld_pkg::PH_OP0F;
            end else begin
               op_upd = {1'b0, in_byte_ff};
               if (!x86ld_pkg::op_known(op_upd)) begin
                  done    = 1'b1;
                  unknown = 1'b1;
               end else if (x86ld_pkg::op_modrm(op_upd)) begin
                  phase_upd = x86ld_pkg::PH_MODRM;
               end else begin
                  go_imm = 1'b1;
               end
            end
         end
      endcase

      dw_new = x86ld_pkg::disp_width(modrm_upd, sib_upd);
      iw_new = x86ld_pkg::imm_width(op_upd, rex_upd[3], modrm_upd[5:3]);
      if (go_disp) begin
         if (dw_new == 3'd0) begin
            go_imm = 1'b1;
         end else begin
            disp_left_upd = dw_new;
            phase_upd     = x86ld_pkg::PH_DISP;
         end
      end
      if (go_imm) begin
         if (iw_new == 4'd0) begin
            done = 1'b1;
         end else begin
            imm_left_upd = iw_new;
            phase_upd    = x86ld_pkg::PH_IMM;
         end
      end

      overlong = (len >= 4'(MAX_LEN));
      emit     = done || overlong || in_last_ff;

      len_in   = (!done && overlong) ? 4'(MAX_LEN) : len;
      st_in    = done ? (unknown ? x86ld_pkg::ST_UNKNOWN : x86ld_pkg::ST_OK) :
                 (overlong ? x86ld_pkg::ST_OVERLONG : x86ld_pkg::ST_TRUNC);
      am_in    = x86ld_pkg::AM_NONE;
      reg_in   = 4'd0;
      rm_in    = 4'd0;
      idx_in   = x86ld_pkg::NO_INDEX;
      scale_in = 2'd0;
      rdisp_in = 32'd0;
      rimm_in  = 64'd0;
      sib_idx  = {rex_upd[1], sib_upd[5:3]};
      if (done && !unknown) begin
         if (x86ld_pkg::op_modrm(op_upd)) begin
            reg_in = {rex_upd[2], modrm_upd[5:3]};
            if (modrm_upd[7:6] == 2'd3) begin
               am_in = x86ld_pkg::AM_REG;
               rm_in = {rex_upd[0], modrm_upd[2:0]};
            end else if (modrm_upd[2:0] == 3'd4) begin
               am_in    = x86ld_pkg::AM_SIB;
               rm_in    = {rex_upd[0], sib_upd[2:0]};
               idx_in   = (sib_idx == 4'd4) ? x86ld_pkg::NO_INDEX : {1'b0, sib_idx};
               scale_in = sib_upd[7:6];
            end else if (modrm_upd[7:6] == 2'd0 && modrm_upd[2:0] == 3'd5) begin
               am_in = x86ld_pkg::AM_RIP;
            end else begin
               am_in = x86ld_pkg::AM_BASE;
               rm_in = {rex_upd[0], modrm_upd[2:0]};
            end
            rdisp_in = (dw_new == 3'd1) ? {{24{disp_upd[7]}}, disp_upd[7:0]} : disp_upd;
         end
         if (iw_new == 4'd1) begin
            rimm_in = {{56{imm_upd[7]}}, imm_upd[7:0]};
         end else if (iw_new == 4'd4) begin
            rimm_in = {{32{imm_upd[31]}}, imm_upd[31:0]};
         end else begin
            rimm_in = imm_upd;
         end
      end

      if (emit) begin
         phase_in     = x86ld_pkg::PH_PREFIX;
         cnt_in       = 4'd0;
         op_in        = 9'd0;
         rex_in       = 4'd0;
         pfx_in       = 3'd0;
         modrm_in     = 8'd0;
         sib_in       = 8'd0;
         disp_in      = 32'd0;
         disp_left_in = 3'd0;
         imm_in       = 64'd0;
         imm_left_in  = 4'd0;
      end else begin
         phase_in     = phase_upd;
         cnt_in       = len;
         op_in        = op_upd;
         rex_in       = rex_upd;
         pfx_in       = pfx_upd;
         modrm_in     = modrm_upd;
         sib_in       = sib_upd;
         disp_in      = disp_upd;
         disp_left_in = disp_left_upd;
         imm_in       = imm_upd;
         imm_left_in  = imm_left_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= x86ld_pkg::PH_PREFIX;
         cnt_ff       <= 4'd0;
         op_ff        <= 9'd0;
         rex_ff       <= 4'd0;
         pfx_ff       <= 3'd0;
         modrm_ff     <= 8'd0;
         sib_ff       <= 8'd0;
         disp_ff      <= 32'd0;
         disp_left_ff <= 3'd0;
         imm_ff       <= 64'd0;
         imm_left_ff  <= 4'd0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         rex_ff       <= rex_in;
         pfx_ff       <= pfx_in;
         modrm_ff     <= modrm_in;
         sib_ff       <= sib_in;
         disp_ff      <= disp_in;
         disp_left_ff <= disp_left_in;
         imm_ff       <= imm_in;
         imm_left_ff  <= imm_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance && emit) begin
         len_ff   <= len_in;
         ropc_ff  <= op_upd;
         rrex_ff  <= rex_upd;
         rpfx_ff  <= pfx_upd;
         am_ff    <= am_in;
         reg_ff   <= reg_in;
         rm_ff    <= rm_in;
         idx_ff   <= idx_in;
         scale_ff <= scale_in;
         rdisp_ff <= rdisp_in;
         rimm_ff  <= rimm_in;
         st_ff    <= st_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_length       = len_ff;
   assign rsp_opcode       = ropc_ff;
   assign rsp_rex_bits     = rrex_ff;
   assign rsp_prefix_flags = rpfx_ff;
   assign rsp_addr_mode    = am_ff;
   assign rsp_reg_field    = reg_ff;
   assign rsp_rm_or_base   = rm_ff;
   assign rsp_index_reg    = idx_ff;
   assign rsp_scale_log2   = scale_ff;
   assign rsp_displacement = rdisp_ff;
   assign rsp_immediate    = rimm_ff;
   assign rsp_status       = st_ff;

   // Every emitted record leaves the decoder in its starting state.
   a_clear_after_record: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (phase_ff == x86ld_pkg::PH_PREFIX && cnt_ff == 4'd0 &&
                             rex_ff == 4'd0 && pfx_ff == 3'd0))
      else $error("decoder state not cleared after a record");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < 4'(MAX_LEN))
      else $error("byte count reached the length limit without a record");

   a_prefix_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == x86ld_pkg::PH_PREFIX) |-> (disp_left_ff == 3'd0 && imm_left_ff == 4'd0))
      else $error("pending displacement or immediate bytes in the prefix phase");

   a_record_length: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (len_ff != 4'd0 && len_ff <= 4'(MAX_LEN)))
      else $error("record length out of range");

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// tb: self-checking testbench for the x86-64 subset length decoder
// Streams directed and random code bytes through the request channel, predicts
// every decoded record inside the testbench and compares each field of the
// response channel against it, with random idle cycles and stalls on both sides.
// ============================================================================
module tb;

   localparam int DEC_MAX_LEN  = x86ld_pkg::MAX_LEN_DEF;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_BYTES = 600;

   typedef struct {
      logic [3:0]  length;
      logic [8:0]  opcode;
      logic [3:0]  rex_bits;
      logic [2:0]  prefix_flags;
      logic [2:0]  addr_mode;
      logic [3:0]  reg_field;
      logic [3:0]  rm_or_base;
      logic [4:0]  index_reg;
      logic [1:0]  scale_log2;
      logic [31:0] displacement;
      logic [63:0] immediate;
      logic [1:0]  status;
   } insn_record_type;

   typedef struct {
      logic [7:0] code;
      logic       last;
   } code_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_code_byte = 8'h00;
   logic               req_range_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_length;
   logic [8:0]         rsp_opcode;
   logic [3:0]         rsp_rex_bits;
   logic [2:0]         rsp_prefix_flags;
   logic [2:0]         rsp_addr_mode;
   logic [3:0]         rsp_reg_field;
   logic [3:0]         rsp_rm_or_base;
   logic [4:0]         rsp_index_reg;
   logic [1:0]         rsp_scale_log2;
   logic signed [31:0] rsp_displacement;
   logic signed [63:0] rsp_immediate;
   logic [1:0]         rsp_status;

   int  cycle_count = 0;
   int  error_count = 0;
   int  record_count = 0;
   int  queued_bytes = 0;
   logic quiet_stretch;

   code_request_type pending_requests[$];
   insn_record_type  expected_records[$];

   x86ld_pkg::phase_type dec_phase;
   logic [3:0]  dec_count;
   logic [8:0]  dec_opcode;
   logic [3:0]  dec_rex;
   logic [2:0]  dec_prefix;
   logic [7:0]  dec_modrm;
   logic [7:0]  dec_sib;
   logic [31:0] dec_disp;
   int          dec_disp_left;
   logic [63:0] dec_imm;
   int          dec_imm_left;

   x86_64_subset_length_decoder_top #(
      .MAX_LEN(DEC_MAX_LEN)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_byte   (req_code_byte),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_length      (rsp_length),
      .rsp_opcode      (rsp_opcode),
      .rsp_rex_bits    (rsp_rex_bits),
      .rsp_prefix_flags(rsp_prefix_flags),
      .rsp_addr_mode   (rsp_addr_mode),
      .rsp_reg_field   (rsp_reg_field),
      .rsp_rm_or_base  (rsp_rm_or_base),
      .rsp_index_reg   (rsp_index_reg),
      .rsp_scale_log2  (rsp_scale_log2),
      .rsp_displacement(rsp_displacement),
      .rsp_immediate   (rsp_immediate),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   assign quiet_stretch = (cycle_count >= 150) && (cycle_count < 450);

   function automatic bit opc_is_known(input logic [8:0] op);
      logic [7:0] b;
      b = op[7:0];
      if (op[8]) begin
         return b inside {[8'h80:8'h8F], 8'hB6, 8'hB7, 8'hAF, 8'h10, 8'h11, 8'h2A,
                          8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h54, 8'h56, 8'h57, 8'h58,
                          8'h59, 8'h5C, 8'h5E, 8'h6E, 8'h7E};
      end
      if (b < 8'h40) begin
         return b[2:0] < 3'd4;
      end
      return b inside {[8'h50:8'h5F], [8'hB8:8'hBF], [8'h70:8'h7F], 8'h88, 8'h89,
                       8'h8A, 8'h8B, 8'h8D, 8'h63, x86ld_pkg::OP_IMUL_IMM32,
                       x86ld_pkg::OP_IMUL_IMM8, x86ld_pkg::OP_MOV_RM_IMM, 8'h81, 8'h83,
                       8'hD2, 8'hD3, 8'hF7, 8'hFF, 8'hC3, 8'h99, 8'hFC, 8'hA4,
                       x86ld_pkg::OP_CALL, 8'hE9, 8'hEB};
   endfunction

   function automatic bit opc_has_modrm(input logic [8:0] op);
      if (op[8]) begin
         return !(op[7:0] inside {[8'h80:8'h8F]});
      end
      return (op[7:0] < 8'h40) ||
             (op[7:0] inside {8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8D, 8'h63,
                              x86ld_pkg::OP_IMUL_IMM32, x86ld_pkg::OP_IMUL_IMM8,
                              x86ld_pkg::OP_MOV_RM_IMM, 8'h81, 8'h83, 8'hD2, 8'hD3,
                              8'hF7, 8'hFF});
   endfunction

   function automatic int imm_bytes(input logic [8:0] op, input logic rex_w,
                                    input logic [7:0] modrm);
      if (op[8]) begin
         return (op[7:0] inside {[8'h80:8'h8F]}) ? 4 : 0;
      end
      if (op[7:0] inside {[8'hB8:8'hBF]}) begin
         return rex_w ? 8 : 4;
      end
      if (op[7:0] inside {[8'h70:8'h7F]}) begin
         return 1;
      end
      case (op[7:0])
         x86ld_pkg::OP_IMUL_IMM32, x86ld_pkg::OP_MOV_RM_IMM, 8'h81, x86ld_pkg::OP_CALL,
         8'hE9: return 4;
         x86ld_pkg::OP_IMUL_IMM8, 8'h83, 8'hEB: return 1;
         8'hF7: return (modrm[5:3] < 3'd2) ? 4 : 0;
         default: return 0;
      endcase
   endfunction

   function automatic int disp_bytes(input logic [7:0] modrm, input logic [7:0] sib);
      case (modrm[7:6])
         2'd3: return 0;
         2'd1: return 1;
         2'd2: return 4;
         default: begin
            if (modrm[2:0] == 3'd4) begin
               return (sib[2:0] == 3'd5) ? 4 : 0;
            end
            return (modrm[2:0] == 3'd5) ? 4 : 0;
         end
      endcase
   endfunction

   task automatic clear_decode();
      dec_phase     = x86ld_pkg::PH_PREFIX;
      dec_count     = 4'd0;
      dec_opcode    = 9'd0;
      dec_rex       = 4'd0;
      dec_prefix    = 3'd0;
      dec_modrm     = 8'd0;
      dec_sib       = 8'd0;
      dec_disp      = 32'd0;
      dec_disp_left = 0;
      dec_imm       = 64'd0;
      dec_imm_left  = 0;
   endtask

   task automatic open_immediate(output bit complete);
      int n;
      n = imm_bytes(dec_opcode, dec_rex[3], dec_modrm);
      complete = (n == 0);
      if (n != 0) begin
         dec_imm_left = n;
         dec_phase = x86ld_pkg::PH_IMM;
      end
   endtask

   task automatic open_displacement(output bit complete);
      int n;
      n = disp_bytes(dec_modrm, dec_sib);
      complete = 1'b0;
      if (n == 0) begin
         open_immediate(complete);
      end else begin
         dec_disp_left = n;
         dec_phase = x86ld_pkg::PH_DISP;
      end
   endtask

   task automatic take_opcode(input logic [8:0] op, output bit complete,
                              output logic [1:0] st);
      dec_opcode = op;
      complete = 1'b0;
      st = x86ld_pkg::ST_OK;
      if (!opc_is_known(op)) begin
         complete = 1'b1;
         st = x86ld_pkg::ST_UNKNOWN;
      end else if (opc_has_modrm(op)) begin
         dec_phase = x86ld_pkg::PH_MODRM;
      end else begin
         open_immediate(complete);
      end
   endtask

   function automatic insn_record_type partial_record(input logic [3:0] len,
                                                      input logic [1:0] st);
      insn_record_type r;
      r.length       = len;
      r.opcode       = dec_opcode;
      r.rex_bits     = dec_rex;
      r.prefix_flags = dec_prefix;
      r.addr_mode    = x86ld_pkg::AM_NONE;
      r.reg_field    = 4'd0;
      r.rm_or_base   = 4'd0;
      r.index_reg    = x86ld_pkg::NO_INDEX;
      r.scale_log2   = 2'd0;
      r.displacement = 32'd0;
      r.immediate    = 64'd0;
      r.status       = st;
      return r;
   endfunction

   function automatic insn_record_type full_record(input logic [3:0] len);
      insn_record_type r;
      logic [3:0]      idx;
      int              dw;
      int              iw;
      r = partial_record(len, x86ld_pkg::ST_OK);
      dw = disp_bytes(dec_modrm, dec_sib);
      iw = imm_bytes(dec_opcode, dec_rex[3], dec_modrm);
      if (opc_has_modrm(dec_opcode)) begin
         r.reg_field = {dec_rex[2], dec_modrm[5:3]};
         if (dec_modrm[7:6] == 2'd3) begin
            r.addr_mode  = x86ld_pkg::AM_REG;
            r.rm_or_base = {dec_rex[0], dec_modrm[2:0]};
         end else if (dec_modrm[2:0] == 3'd4) begin
            idx = {dec_rex[1], dec_sib[5:3]};
            r.addr_mode  = x86ld_pkg::AM_SIB;
            r.rm_or_base = {dec_rex[0], dec_sib[2:0]};
            r.index_reg  = (idx == 4'd4) ? x86ld_pkg::NO_INDEX : {1'b0, idx};
            r.scale_log2 = dec_sib[7:6];
         end else if (dec_modrm[7:6] == 2'd0 && dec_modrm[2:0] == 3'd5) begin
            r.addr_mode = x86ld_pkg::AM_RIP;
         end else begin
            r.addr_mode  = x86ld_pkg::AM_BASE;
            r.rm_or_base = {dec_rex[0], dec_modrm[2:0]};
         end
         r.displacement = (dw == 1) ? {{24{dec_disp[7]}}, dec_disp[7:0]} : dec_disp;
      end
      case (iw)
         1: r.immediate = {{56{dec_imm[7]}}, dec_imm[7:0]};
         4: r.immediate = {{32{dec_imm[31]}}, dec_imm[31:0]};
         default: r.immediate = dec_imm;
      endcase
      return r;
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic last);
      bit         complete;
      logic [1:0] st;
      logic [3:0] len;
      int         pos;
      complete = 1'b0;
      st = x86ld_pkg::ST_OK;
      dec_count = dec_count + 4'd1;
      len = dec_count;
      case (dec_phase)
         x86ld_pkg::PH_OP0F: begin
            take_opcode({1'b1, b}, complete, st);
         end
         x86ld_pkg::PH_MODRM: begin
            dec_modrm = b;
            if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
               dec_phase = x86ld_pkg::PH_SIB;
            end else begin
               open_displacement(complete);
            end
         end
         x86ld_pkg::PH_SIB: begin
            dec_sib = b;
            open_displacement(complete);
         end
         x86ld_pkg::PH_DISP: begin
            pos = disp_bytes(dec_modrm, dec_sib) - dec_disp_left;
            dec_disp = dec_disp | (32'(b) << (8 * pos));
            dec_disp_left = dec_disp_left - 1;
            if (dec_disp_left == 0) begin
               open_immediate(complete);
            end
         end
         x86ld_pkg::PH_IMM: begin
            pos = imm_bytes(dec_opcode, dec_rex[3], dec_modrm) - dec_imm_left;
            dec_imm = dec_imm | (64'(b) << (8 * pos));
            dec_imm_left = dec_imm_left - 1;
            complete = (dec_imm_left == 0);
         end
         default: begin
            if (b == x86ld_pkg::PFX_OPSIZE) begin
               dec_prefix[0] = 1'b1;
               dec_rex = 4'd0;
            end else if (b == x86ld_pkg::PFX_REPNE) begin
               dec_prefix[2:1] = 2'b01;
               dec_rex = 4'd0;
            end else if (b == x86ld_pkg::PFX_REP) begin
               dec_prefix[2:1] = 2'b10;
               dec_rex = 4'd0;
            end else if (b == x86ld_pkg::PFX_ADDR || b == x86ld_pkg::PFX_LOCK) begin
               dec_rex = 4'd0;
            end else if (b[7:4] == x86ld_pkg::REX_BASE[7:4]) begin
               dec_rex = b[3:0];
            end else if (b == x86ld_pkg::ESC_0F) begin
               dec_opcode = 9'h100;
               dec_phase = x86ld_pkg::PH_OP0F;
            end else begin
               take_opcode({1'b0, b}, complete, st);
            end
         end
      endcase
      if (complete) begin
         expected_records.push_back((st == x86ld_pkg::ST_OK) ? full_record(len) :
                                    partial_record(len, st));
         clear_decode();
      end else if (len >= DEC_MAX_LEN) begin
         expected_records.push_back(partial_record(4'(DEC_MAX_LEN),
                                                   x86ld_pkg::ST_OVERLONG));
         clear_decode();
      end else if (last) begin
         expected_records.push_back(partial_record(len, x86ld_pkg::ST_TRUNC));
         clear_decode();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      code_request_type r;
      r.code = b;
      r.last = last;
      pending_requests.push_back(r);
      queued_bytes++;
   endtask

   task automatic send_packed(input logic [127:0] seq, input int n, input bit end_range);
      for (int i = 0; i < n; i++) begin
         send_byte(seq[8 * (n - 1 - i) +: 8], end_range && (i == n - 1));
      end
   endtask

   task automatic queue_random_instruction();
      logic [7:0] bytes[$];
      logic [7:0] b;
      logic [7:0] modrm;
      logic [7:0] sib;
      logic [8:0] op;
      logic [3:0] rex_eff;
      int         npfx;
      int         roll;
      int         cut;
      rex_eff = 4'd0;
      modrm = 8'd0;
      sib = 8'd0;
      npfx = ($urandom_range(0, 99) < 4) ? $urandom_range(10, 16) : $urandom_range(0, 3);
      repeat (npfx) begin
         case ($urandom_range(0, 5))
            0: b = x86ld_pkg::PFX_OPSIZE;
            1: b = x86ld_pkg::PFX_REPNE;
            2: b = x86ld_pkg::PFX_REP;
            3: b = x86ld_pkg::PFX_ADDR;
            4: b = x86ld_pkg::PFX_LOCK;
            default: b = x86ld_pkg::REX_BASE | 8'($urandom_range(0, 15));
         endcase
         rex_eff = (b[7:4] == x86ld_pkg::REX_BASE[7:4]) ? b[3:0] : 4'd0;
         bytes.push_back(b);
      end
      if ($urandom_range(0, 1) == 1) begin
         b = x86ld_pkg::REX_BASE | 8'($urandom_range(0, 15));
         rex_eff = b[3:0];
         bytes.push_back(b);
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         do op = {1'b0, 8'($urandom())}; while (!opc_is_known(op));
      end else if (roll < 88) begin
         do op = {1'b1, 8'($urandom())}; while (!opc_is_known(op));
         bytes.push_back(x86ld_pkg::ESC_0F);
      end else begin
         op = {1'b0, 8'($urandom())};
      end
      bytes.push_back(op[7:0]);
      if (opc_is_known(op)) begin
         if (opc_has_modrm(op)) begin
            modrm = 8'($urandom());
            bytes.push_back(modrm);
            if (modrm[7:6] != 2'd3 && modrm[2:0] == 3'd4) begin
               sib = 8'($urandom());
               bytes.push_back(sib);
            end
            repeat (disp_bytes(modrm, sib)) bytes.push_back(8'($urandom()));
         end
         repeat (imm_bytes(op, rex_eff[3], modrm)) bytes.push_back(8'($urandom()));
      end
      roll = $urandom_range(0, 99);
      if (roll < 6 && bytes.size() > 1) begin
         cut = $urandom_range(0, bytes.size() - 2);
      end else begin
         cut = bytes.size() - 1;
      end
      for (int i = 0; i <= cut; i++) begin
         send_byte(bytes[i], (i == cut) && (cut < bytes.size() - 1 || roll > 94));
      end
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("tb: mismatch on record %0d: %s", record_count, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_proc
      code_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_byte(req_code_byte, req_range_end);
         end
         if (pending_requests.size() == 0 ||
             (!quiet_stretch && $urandom_range(0, 99) < 10)) begin
            req_valid <= 1'b0;
         end else begin
            nxt = pending_requests.pop_front();
            req_valid     <= 1'b1;
            req_code_byte <= nxt.code;
            req_range_end <= nxt.last;
         end
      end
   end

   always @(posedge clock) begin : watch_proc
      insn_record_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            record_count++;
            if (expected_records.size() == 0) begin
               report_mismatch("record arrived with none expected");
            end else begin
               want = expected_records.pop_front();
               check_field("length", 64'(rsp_length), 64'(want.length));
               check_field("opcode", 64'(rsp_opcode), 64'(want.opcode));
               check_field("rex_bits", 64'(rsp_rex_bits), 64'(want.rex_bits));
               check_field("prefix_flags", 64'(rsp_prefix_flags),
                           64'(want.prefix_flags));
               check_field("addr_mode", 64'(rsp_addr_mode), 64'(want.addr_mode));
               check_field("reg_field", 64'(rsp_reg_field), 64'(want.reg_field));
               check_field("rm_or_base", 64'(rsp_rm_or_base), 64'(want.rm_or_base));
               check_field("index_reg", 64'(rsp_index_reg), 64'(want.index_reg));
               check_field("scale_log2", 64'(rsp_scale_log2), 64'(want.scale_log2));
               check_field("displacement", 64'($unsigned(rsp_displacement)),
                           64'(want.displacement));
               check_field("immediate", $unsigned(rsp_immediate), want.immediate);
               check_field("status", 64'(rsp_status), 64'(want.status));
            end
         end
         rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < 10);
      end
   end

   initial begin : stimulus_proc
      int random_start;
      clear_decode();

      // Unknown opcodes in both maps, a 64-bit immediate, REX cancelled by a
      // legacy prefix on a RIP-relative load, the test group with imm32 and
      // the last rep prefix winning, then truncation mid-instruction and on a
      // lone prefix.
      send_packed(128'h90, 1, 1'b0);
      send_packed(128'h0F0B, 2, 1'b0);
      send_packed(128'h48BF0123456789ABCDEF, 10, 1'b0);
      send_packed(128'h4C668B05785634F2, 8, 1'b0);
      send_packed(128'hF2F3F7C000000080, 8, 1'b1);
      send_packed(128'h83C0, 2, 1'b1);
      send_packed(128'hF3, 1, 1'b1);

      random_start = queued_bytes;
      while (queued_bytes < random_start + RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom()), $urandom_range(0, 15) == 0);
         end else begin
            queue_random_instruction();
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_records.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
